### design/rhh_pkg.sv
// ----------------------------------------------------------------------------
// rhh_pkg
// Shared widths, codes, types and helpers of the robin hood hash table unit.
// ----------------------------------------------------------------------------
package rhh_pkg;

   localparam int SLOTS   = 1024;
   localparam int SLOT_W  = $clog2(SLOTS);
   localparam int DIST_W  = SLOT_W + 1;
   localparam int CNT_W   = SLOT_W + 1;
   localparam int STEP_W  = 2 * SLOT_W + 1;
   localparam int KEY_W   = 64;
   localparam int VAL_W   = 32;
   localparam int HASH_W  = 32;
   localparam int OP_W    = 2;
   localparam int ST_W    = 2;
   localparam int MAXE_W  = 10;
   localparam int MODE_W  = 2;
   localparam int CSR_W   = 10;
   localparam int CSR_IDX_W = 1;
   localparam int QDEPTH  = 2;
   localparam int QPTR_W  = $clog2(QDEPTH);

   localparam logic [STEP_W-1:0] STEP_CAP = {1'b1, {(STEP_W-1){1'b0}}};
   localparam logic [HASH_W-1:0] HASH_DEL = 32'h8000_0000;

   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
   localparam logic [OP_W-1:0] OP_UNDEF  = 2'd3;

   localparam logic [ST_W-1:0] ST_OK       = 2'd0;
   localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL     = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_MAX_ENTRIES = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_MODE    = 1'd1;

   localparam logic [MODE_W-1:0] KEY_MODE_16    = 2'd0;
   localparam logic [MODE_W-1:0] KEY_MODE_32    = 2'd1;
   localparam logic [MODE_W-1:0] KEY_MODE_64    = 2'd2;
   localparam logic [MODE_W-1:0] KEY_MODE_UNDEF = 2'd3;

   localparam logic [MAXE_W-1:0] MAX_ENTRIES_RST = 10'd819;
   localparam logic [MODE_W-1:0] KEY_MODE_RST    = KEY_MODE_32;

   localparam logic [63:0] MIX64_C1 = 64'hff51_afd7_ed55_8ccd;
   localparam logic [63:0] MIX64_C2 = 64'hc4ce_b9fe_1a85_ec53;
   localparam logic [63:0] MIX32_C1 = 64'h0000_0000_85eb_ca6b;
   localparam logic [63:0] MIX32_C2 = 64'h0000_0000_c2b2_ae35;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [KEY_W-1:0]  key;
      logic [VAL_W-1:0]  value;
      logic [DIST_W-1:0] resume_distance;
      logic [HASH_W-1:0] hash;
   } work_type;

   typedef struct packed {
      logic [MAXE_W-1:0] max_entries;
      logic [MODE_W-1:0] key_mode;
   } cfg_type;

   typedef struct packed {
      logic [HASH_W-1:0] hash;
      logic [KEY_W-1:0]  key;
      logic [VAL_W-1:0]  value;
   } row_type;

   typedef enum logic [1:0] {F_IDLE, F_HASH, F_PUSH} front_state_type;
   typedef enum logic [2:0] {B_CLEAR, B_IDLE, B_READ, B_EVAL, B_DONE} back_state_type;

   function automatic logic [KEY_W-1:0] key_mask(input logic [MODE_W-1:0] mode);
      logic [KEY_W-1:0] m;
      case (mode)
         KEY_MODE_16: m = 64'h0000_0000_0000_ffff;
         KEY_MODE_32: m = 64'h0000_0000_ffff_ffff;
         default:     m = '1;
      endcase
      return m;
   endfunction

endpackage

### design/rhh_req_if.sv
// ----------------------------------------------------------------------------
// rhh_req_if
// Request channel: operation, key, value handle and resume distance.
// ----------------------------------------------------------------------------
interface rhh_req_if;
   logic                       valid;
   logic                       ready;
   logic [rhh_pkg::OP_W-1:0]   op;
   logic [rhh_pkg::KEY_W-1:0]  key;
   logic [rhh_pkg::VAL_W-1:0]  value;
   logic [rhh_pkg::DIST_W-1:0] resume_distance;

   modport source(output valid, op, key, value, resume_distance, input ready);
   modport sink(input valid, op, key, value, resume_distance, output ready);
endinterface

### design/rhh_rsp_if.sv
// ----------------------------------------------------------------------------
// rhh_rsp_if
// Response channel: status, found handle, next distance and entry total.
// ----------------------------------------------------------------------------
interface rhh_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [rhh_pkg::ST_W-1:0]   status;
   logic [rhh_pkg::VAL_W-1:0]  found_value;
   logic [rhh_pkg::DIST_W-1:0] next_distance;
   logic [rhh_pkg::CNT_W-1:0]  entry_total;

   modport source(output valid, status, found_value, next_distance, entry_total,
                  input ready);
   modport sink(input valid, status, found_value, next_distance, entry_total,
                output ready);
endinterface

### design/robin_hood_hash_table_unit.sv
// ----------------------------------------------------------------------------
// robin_hood_hash_table_unit
// Open-addressed robin hood hash table with tombstones, 1024 slots.
// ----------------------------------------------------------------------------
// Usage: requests arrive on req_chan (op, key, value, resume_distance) and
// each produces exactly one response on rsp_chan (status, found_value,
// next_distance, entry_total), in request order. A transfer happens when
// valid and ready are both high. max_entries and key_mode are to be written
// through csr_we / csr_index / csr_data only while the unit is idle; the
// unit itself does not enforce this.
// Flow: hashing runs on the shared 32x32 multiplier, then each probe of the
// single-port slot memory is a read, then an evaluate and write, then the
// result is handed off to the response register. The hashing of the next
// request overlaps the probe walk of the current one; the front end takes
// a new request only after pushing the last one to the queue.
// Reset: a clearing pass writes all 1024 slots to free, one per cycle; req
// ready stays low during the pass. Config writes are taken throughout.
// Stall: the response register holds until taken; the probe engine waits on
// it and the two-entry queue and the hash front end back up behind it.
// ----------------------------------------------------------------------------
module robin_hood_hash_table_unit (
   input  logic                           clock,
   input  logic                           reset,
   rhh_req_if.sink                        req_chan,
   rhh_rsp_if.source                      rsp_chan,
   input  logic                           csr_we,
   input  logic [rhh_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rhh_pkg::CSR_W-1:0]      csr_data
);

   logic [rhh_pkg::MAXE_W-1:0] max_ff, max_in;
   logic [rhh_pkg::MODE_W-1:0] mode_ff, mode_in;
   rhh_pkg::cfg_type           cfg;
   rhh_pkg::work_type          push_data;
   rhh_pkg::work_type          pop_data;
   logic                       push_valid, push_ready;
   logic                       pop_valid, pop_ready;
   logic                       clearing;

   always_comb begin
      max_in  = max_ff;
      mode_in = mode_ff;
      if (csr_we) begin
         case (csr_index)
            rhh_pkg::REG_MAX_ENTRIES: max_in  = csr_data[rhh_pkg::MAXE_W-1:0];
            rhh_pkg::REG_KEY_MODE:    mode_in = csr_data[rhh_pkg::MODE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff  <= rhh_pkg::MAX_ENTRIES_RST;
         mode_ff <= rhh_pkg::KEY_MODE_RST;
      end else begin
         max_ff  <= max_in;
         mode_ff <= mode_in;
      end
   end

   assign cfg.max_entries = max_ff;
   assign cfg.key_mode    = mode_ff;

   rhh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .clearing   (clearing),
      .key_mode   (mode_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   rhh_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   rhh_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .clearing  (clearing),
      .rsp_chan  (rsp_chan)
   );

`ifndef SYNTH
   a_no_req_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_chan.ready)
      else $error("request taken during clearing pass");

   a_no_rsp_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !rsp_chan.valid && !pop_valid)
      else $error("work present during clearing pass");

   a_total_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.entry_total <= rhh_pkg::CNT_W'(rhh_pkg::SLOTS))
      else $error("entry total beyond capacity");

   a_found_has_distance: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.next_distance != '0 |-> rsp_chan.status == rhh_pkg::ST_OK)
      else $error("next distance on a miss");
`endif

endmodule

### design/rhh_front.sv
// ----------------------------------------------------------------------------
// rhh_front
// Accepts requests, masks the key and runs the murmur finalizer on one
// shared 32x32 multiplier, then hands the work item to the queue.
// ----------------------------------------------------------------------------
module rhh_front (
   input  logic                        clock,
   input  logic                        reset,
   rhh_req_if.sink                     req_chan,
   input  logic                        clearing,
   input  logic [rhh_pkg::MODE_W-1:0]  key_mode,
   output logic                        push_valid,
   input  logic                        push_ready,
   output rhh_pkg::work_type           push_data
);

   rhh_pkg::front_state_type state_ff, state_in;
   logic [rhh_pkg::OP_W-1:0]   op_ff, op_in;
   logic [rhh_pkg::KEY_W-1:0]  key_ff, key_in;
   logic [rhh_pkg::VAL_W-1:0]  val_ff, val_in;
   logic [rhh_pkg::DIST_W-1:0] rd_ff, rd_in;
   logic [rhh_pkg::HASH_W-1:0] hash_ff, hash_in;
   logic [63:0] x_ff, x_in;
   logic [63:0] sum_ff, sum_in;
   logic [63:0] prod_ff, prod_in;
   logic [2:0]  step_ff, step_in;
   logic        rnd_ff, rnd_in;

   logic                       wide;
   logic                       accept;
   logic [rhh_pkg::KEY_W-1:0]  mkey;
   logic [31:0]                mkey_lo;
   logic [63:0]                x_load;
   logic [63:0]                mix_c;
   logic [31:0]                mul_a;
   logic [31:0]                mul_b;
   logic [63:0]                mul_p;
   logic [31:0]                sum_lo;
   logic [63:0]                fin_x;
   logic [rhh_pkg::HASH_W-1:0] hash_fix;

   assign wide    = key_mode[1];
   assign accept  = req_chan.valid && req_chan.ready;
   assign mkey    = req_chan.key & rhh_pkg::key_mask(key_mode);
   assign mkey_lo = mkey[31:0];
   assign x_load  = wide ? (mkey ^ (mkey >> 33)) : {32'b0, mkey_lo ^ (mkey_lo >> 16)};

   assign mix_c = wide ? (rnd_ff ? rhh_pkg::MIX64_C2 : rhh_pkg::MIX64_C1)
                       : (rnd_ff ? rhh_pkg::MIX32_C2 : rhh_pkg::MIX32_C1);
   // three partial products give the low 64 bits of a 64x64 product
   assign mul_a = (step_ff == 3'd2) ? x_ff[63:32] : x_ff[31:0];
   assign mul_b = (step_ff == 3'd1) ? mix_c[63:32] : mix_c[31:0];
   assign mul_p = mul_a * mul_b;

   assign sum_lo   = sum_ff[31:0];
   assign fin_x    = wide ? (sum_ff ^ (sum_ff >> 33))
                          : {32'b0, sum_lo ^ (rnd_ff ? (sum_lo >> 16) : (sum_lo >> 13))};
   assign hash_fix = (fin_x[30:0] == 31'd0) ? 32'd1 : {1'b0, fin_x[30:0]};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rhh_pkg::F_IDLE: begin
            if (accept) state_in = rhh_pkg::F_HASH;
         end
         rhh_pkg::F_HASH: begin
            if (step_ff == 3'd4 && rnd_ff) state_in = rhh_pkg::F_PUSH;
         end
         rhh_pkg::F_PUSH: begin
            if (push_ready) state_in = rhh_pkg::F_IDLE;
         end
         default: state_in = rhh_pkg::F_IDLE;
      endcase
   end

   always_comb begin
      op_in   = op_ff;
      key_in  = key_ff;
      val_in  = val_ff;
      rd_in   = rd_ff;
      hash_in = hash_ff;
      x_in    = x_ff;
      sum_in  = sum_ff;
      prod_in = mul_p;
      step_in = step_ff;
      rnd_in  = rnd_ff;
      req_chan.ready = (state_ff == rhh_pkg::F_IDLE) && !clearing;
      push_valid     = (state_ff == rhh_pkg::F_PUSH);
      case (state_ff)
         rhh_pkg::F_IDLE: begin
            if (accept) begin
               op_in   = req_chan.op;
               key_in  = mkey;
               val_in  = req_chan.value;
               rd_in   = req_chan.resume_distance;
               x_in    = x_load;
               step_in = 3'd0;
               rnd_in  = 1'b0;
            end
         end
         rhh_pkg::F_HASH: begin
            case (step_ff)
               3'd1: sum_in = prod_ff;
               3'd2: sum_in = {sum_ff[63:32] + prod_ff[31:0], sum_ff[31:0]};
               3'd3: sum_in = {sum_ff[63:32] + prod_ff[31:0], sum_ff[31:0]};
               default: sum_in = sum_ff;
            endcase
            if (step_ff == 3'd4) begin
               x_in    = fin_x;
               step_in = 3'd0;
               rnd_in  = 1'b1;
               if (rnd_ff) hash_in = hash_fix;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         default: begin
         end
      endcase
   end

   assign push_data.op              = op_ff;
   assign push_data.key             = key_ff;
   assign push_data.value           = val_ff;
   assign push_data.resume_distance = rd_ff;
   assign push_data.hash            = hash_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rhh_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff   <= op_in;
      key_ff  <= key_in;
      val_ff  <= val_in;
      rd_ff   <= rd_in;
      hash_ff <= hash_in;
      x_ff    <= x_in;
      sum_ff  <= sum_in;
      prod_ff <= prod_in;
      step_ff <= step_in;
      rnd_ff  <= rnd_in;
   end

endmodule

### design/rhh_fifo.sv
// ----------------------------------------------------------------------------
// rhh_fifo
// Short queue of hashed work items between the front and back ends.
// ----------------------------------------------------------------------------
module rhh_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  rhh_pkg::work_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output rhh_pkg::work_type pop_data
);

   rhh_pkg::work_type q_ff [rhh_pkg::QDEPTH];
   logic [rhh_pkg::QPTR_W-1:0] wp_ff, wp_in;
   logic [rhh_pkg::QPTR_W-1:0] rp_ff, rp_in;
   logic [rhh_pkg::QPTR_W:0]   cnt_ff, cnt_in;
   logic do_push;
   logic do_pop;

   assign push_ready = (cnt_ff != (rhh_pkg::QPTR_W+1)'(rhh_pkg::QDEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_data   = q_ff[rp_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wp_in  = do_push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = do_pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (rhh_pkg::QPTR_W+1)'(do_push) - (rhh_pkg::QPTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) q_ff[wp_ff] <= push_data;
   end

endmodule

### design/rhh_back.sv
// ----------------------------------------------------------------------------
// rhh_back
// Probe engine: owns the slot memory, walks probe sequences for lookup,
// insert and remove, keeps the live count and drives the response register.
// ----------------------------------------------------------------------------
module rhh_back (
   input  logic              clock,
   input  logic              reset,
   input  rhh_pkg::cfg_type  cfg,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  rhh_pkg::work_type pop_data,
   output logic              clearing,
   rhh_rsp_if.source         rsp_chan
);

   rhh_pkg::row_type mem [rhh_pkg::SLOTS];
   rhh_pkg::row_type rdata_ff;

   rhh_pkg::back_state_type state_ff, state_in;
   logic [rhh_pkg::SLOT_W-1:0] clr_ff, clr_in;
   logic [rhh_pkg::OP_W-1:0]   op_ff, op_in;
   logic [rhh_pkg::HASH_W-1:0] h_ff, h_in;
   logic [rhh_pkg::KEY_W-1:0]  k_ff, k_in;
   logic [rhh_pkg::VAL_W-1:0]  v_ff, v_in;
   logic [rhh_pkg::DIST_W-1:0] d_ff, d_in;
   logic [rhh_pkg::STEP_W-1:0] steps_ff, steps_in;
   logic [rhh_pkg::CNT_W-1:0]  live_ff, live_in;
   logic [rhh_pkg::ST_W-1:0]   res_st_ff, res_st_in;
   logic [rhh_pkg::VAL_W-1:0]  res_val_ff, res_val_in;
   logic [rhh_pkg::DIST_W-1:0] res_nd_ff, res_nd_in;
   logic                       ov_ff, ov_in;
   logic [rhh_pkg::ST_W-1:0]   o_st_ff;
   logic [rhh_pkg::VAL_W-1:0]  o_val_ff;
   logic [rhh_pkg::DIST_W-1:0] o_nd_ff;
   logic [rhh_pkg::CNT_W-1:0]  o_tot_ff;

   logic                       mem_we;
   logic                       mem_re;
   logic [rhh_pkg::SLOT_W-1:0] mem_wa;
   rhh_pkg::row_type           mem_wd;
   logic                       out_free;
   logic                       out_load;

   logic [rhh_pkg::SLOT_W-1:0] idx;
   logic [rhh_pkg::SLOT_W-1:0] bd;
   logic [rhh_pkg::HASH_W-1:0] bh;
   logic [rhh_pkg::DIST_W-1:0] d_next;
   logic [rhh_pkg::DIST_W-1:0] d_after;
   logic [rhh_pkg::STEP_W-1:0] steps_next;
   logic                       steal;
   logic                       lk_match, lk_stop, d_end;
   logic                       ins_place, ins_swap, ins_end;
   logic                       rm_hit;
   logic                       table_full;
   logic                       start_done;
   logic [rhh_pkg::ST_W-1:0]   start_st;
   logic                       eval_done;

   assign bh         = rdata_ff.hash;
   assign idx        = h_ff[rhh_pkg::SLOT_W-1:0] + d_ff[rhh_pkg::SLOT_W-1:0];
   assign bd         = idx - bh[rhh_pkg::SLOT_W-1:0];
   assign steal      = d_ff > {1'b0, bd};
   assign d_next     = d_ff + 1'b1;
   assign d_end      = d_next[rhh_pkg::SLOT_W];
   assign lk_match   = (bh == h_ff) &&
                       ((rdata_ff.key & rhh_pkg::key_mask(cfg.key_mode)) == k_ff);
   assign lk_stop    = (bh != h_ff) && ((bh == '0) || ({1'b0, bd} < d_ff));
   assign ins_place  = (bh == '0) || (bh[rhh_pkg::HASH_W-1] && steal);
   assign ins_swap   = !ins_place && steal;
   assign d_after    = (ins_swap ? {1'b0, bd} : d_ff) + 1'b1;
   assign steps_next = steps_ff + 1'b1;
   // walk gives up at distance SLOTS or at the step cap
   assign ins_end    = d_after[rhh_pkg::SLOT_W] || (steps_next >= rhh_pkg::STEP_CAP);
   assign rm_hit     = (bh == h_ff) && (rdata_ff.value == v_ff);
   assign table_full = (live_ff >= {1'b0, cfg.max_entries}) ||
                       (live_ff >= rhh_pkg::CNT_W'(rhh_pkg::SLOTS));
   assign out_free   = !ov_ff || rsp_chan.ready;
   assign clearing   = (state_ff == rhh_pkg::B_CLEAR);

   always_comb begin
      start_done = 1'b0;
      start_st   = rhh_pkg::ST_OK;
      case (pop_data.op)
         rhh_pkg::OP_LOOKUP: begin
            start_done = pop_data.resume_distance[rhh_pkg::SLOT_W];
            start_st   = rhh_pkg::ST_NOTFOUND;
         end
         rhh_pkg::OP_INSERT: begin
            start_done = table_full;
            start_st   = rhh_pkg::ST_FULL;
         end
         rhh_pkg::OP_REMOVE: begin
            start_done = 1'b0;
         end
         default: begin
            start_done = 1'b1;
            start_st   = rhh_pkg::ST_NOTFOUND;
         end
      endcase
   end

   always_comb begin
      case (op_ff)
         rhh_pkg::OP_LOOKUP: eval_done = lk_match || lk_stop || d_end;
         rhh_pkg::OP_INSERT: eval_done = ins_place || ins_end;
         rhh_pkg::OP_REMOVE: eval_done = rm_hit || d_end;
         default:            eval_done = 1'b1;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rhh_pkg::B_CLEAR: begin
            if (clr_ff == '1) state_in = rhh_pkg::B_IDLE;
         end
         rhh_pkg::B_IDLE: begin
            if (pop_valid) state_in = start_done ? rhh_pkg::B_DONE : rhh_pkg::B_READ;
         end
         rhh_pkg::B_READ: state_in = rhh_pkg::B_EVAL;
         rhh_pkg::B_EVAL: begin
            state_in = eval_done ? rhh_pkg::B_DONE : rhh_pkg::B_READ;
         end
         rhh_pkg::B_DONE: begin
            if (out_free) state_in = rhh_pkg::B_IDLE;
         end
         default: state_in = rhh_pkg::B_IDLE;
      endcase
   end

   always_comb begin
      clr_in     = clr_ff;
      op_in      = op_ff;
      h_in       = h_ff;
      k_in       = k_ff;
      v_in       = v_ff;
      d_in       = d_ff;
      steps_in   = steps_ff;
      live_in    = live_ff;
      res_st_in  = res_st_ff;
      res_val_in = res_val_ff;
      res_nd_in  = res_nd_ff;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      mem_wa     = idx;
      mem_wd     = '{hash: h_ff, key: k_ff, value: v_ff};
      pop_ready  = 1'b0;
      out_load   = 1'b0;
      case (state_ff)
         rhh_pkg::B_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = '0;
            clr_in = clr_ff + 1'b1;
         end
         rhh_pkg::B_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               op_in      = pop_data.op;
               h_in       = pop_data.hash;
               k_in       = pop_data.key;
               v_in       = pop_data.value;
               d_in       = (pop_data.op == rhh_pkg::OP_LOOKUP) ?
                            pop_data.resume_distance : '0;
               steps_in   = '0;
               res_st_in  = start_st;
               res_val_in = '0;
               res_nd_in  = '0;
            end
         end
         rhh_pkg::B_READ: mem_re = 1'b1;
         rhh_pkg::B_EVAL: begin
            case (op_ff)
               rhh_pkg::OP_LOOKUP: begin
                  if (lk_match) begin
                     res_st_in  = rhh_pkg::ST_OK;
                     res_val_in = rdata_ff.value;
                     res_nd_in  = d_next;
                  end else if (lk_stop || d_end) begin
                     res_st_in = rhh_pkg::ST_NOTFOUND;
                  end else begin
                     d_in = d_next;
                  end
               end
               rhh_pkg::OP_INSERT: begin
                  if (ins_place) begin
                     mem_we    = 1'b1;
                     live_in   = live_ff + 1'b1;
                     res_st_in = rhh_pkg::ST_OK;
                  end else begin
                     // richer entry gives up its slot and is carried on
                     if (ins_swap) begin
                        mem_we = 1'b1;
                        h_in   = bh;
                        k_in   = rdata_ff.key;
                        v_in   = rdata_ff.value;
                     end
                     d_in     = d_after;
                     steps_in = steps_next;
                     if (ins_end) res_st_in = rhh_pkg::ST_FULL;
                  end
               end
               rhh_pkg::OP_REMOVE: begin
                  if (rm_hit) begin
                     mem_we    = 1'b1;
                     mem_wd    = '{hash: h_ff | rhh_pkg::HASH_DEL, key: rdata_ff.key,
                                   value: rdata_ff.value};
                     live_in   = (live_ff != '0) ? live_ff - 1'b1 : live_ff;
                     res_st_in = rhh_pkg::ST_OK;
                  end else if (d_end) begin
                     res_st_in = rhh_pkg::ST_NOTFOUND;
                  end else begin
                     d_in = d_next;
                  end
               end
               default: begin
               end
            endcase
         end
         rhh_pkg::B_DONE: out_load = out_free;
         default: begin
         end
      endcase
      ov_in = out_load ? 1'b1 : (rsp_chan.ready ? 1'b0 : ov_ff);
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (mem_re) rdata_ff <= mem[idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rhh_pkg::B_CLEAR;
         clr_ff   <= '0;
         live_ff  <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         live_ff  <= live_in;
         ov_ff    <= ov_in;
      end
      op_ff      <= op_in;
      h_ff       <= h_in;
      k_ff       <= k_in;
      v_ff       <= v_in;
      d_ff       <= d_in;
      steps_ff   <= steps_in;
      res_st_ff  <= res_st_in;
      res_val_ff <= res_val_in;
      res_nd_ff  <= res_nd_in;
      if (out_load) begin
         o_st_ff  <= res_st_ff;
         o_val_ff <= res_val_ff;
         o_nd_ff  <= res_nd_ff;
         o_tot_ff <= live_ff;
      end
   end

   assign rsp_chan.valid         = ov_ff;
   assign rsp_chan.status        = o_st_ff;
   assign rsp_chan.found_value   = o_val_ff;
   assign rsp_chan.next_distance = o_nd_ff;
   assign rsp_chan.entry_total   = o_tot_ff;

endmodule

### tb/robin_hood_hash_table_unit_tb.sv
// ----------------------------------------------------------------------------
// robin_hood_hash_table_unit_tb
// Drives lookups, inserts, removes and undefined operations into the hash
// table unit under random backpressure, predicts every response from its own
// copy of the table and compares each response field by field, in order.
// ----------------------------------------------------------------------------
module robin_hood_hash_table_unit_tb;

   typedef struct packed {
      logic [rhh_pkg::ST_W-1:0]   status;
      logic [rhh_pkg::VAL_W-1:0]  found_value;
      logic [rhh_pkg::DIST_W-1:0] next_distance;
      logic [rhh_pkg::CNT_W-1:0]  entry_total;
   } answer_type;

   typedef struct packed {
      logic [rhh_pkg::KEY_W-1:0] key;
      logic [rhh_pkg::VAL_W-1:0] value;
   } pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [rhh_pkg::CSR_IDX_W-1:0] csr_index = rhh_pkg::REG_MAX_ENTRIES;
   logic [rhh_pkg::CSR_W-1:0] csr_data = '0;

   rhh_req_if req_bus();
   rhh_rsp_if rsp_bus();

   robin_hood_hash_table_unit dut (
      .clock(clock), .reset(reset), .req_chan(req_bus), .rsp_chan(rsp_bus),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   // table copy
   logic [rhh_pkg::HASH_W-1:0] tbl_hash [rhh_pkg::SLOTS];
   logic [rhh_pkg::KEY_W-1:0]  tbl_key  [rhh_pkg::SLOTS];
   logic [rhh_pkg::VAL_W-1:0]  tbl_val  [rhh_pkg::SLOTS];
   int unsigned live_total;
   int unsigned limit_entries;
   logic [rhh_pkg::MODE_W-1:0] cur_mode;

   answer_type pending_answers[$];
   pair_type   stored_pairs[$];
   int  failures = 0;
   bit  busy_free = 0;   // no idling on either side while set
   int  quiet_cycles = 0;

   initial begin
      req_bus.valid = 1'b0;
      req_bus.op = rhh_pkg::OP_LOOKUP;
      req_bus.key = '0;
      req_bus.value = '0;
      req_bus.resume_distance = '0;
      rsp_bus.ready = 1'b0;
   end

   function automatic logic [rhh_pkg::KEY_W-1:0] mode_mask();
      case (cur_mode)
         rhh_pkg::KEY_MODE_16: return 64'h0000_0000_0000_ffff;
         rhh_pkg::KEY_MODE_32: return 64'h0000_0000_ffff_ffff;
         default:              return '1;
      endcase
   endfunction

   function automatic logic [rhh_pkg::HASH_W-1:0] murmur_hash(
         input logic [rhh_pkg::KEY_W-1:0] key);
      logic [63:0] x;
      logic [31:0] h;
      if (cur_mode != rhh_pkg::KEY_MODE_16 && cur_mode != rhh_pkg::KEY_MODE_32) begin
         x = key;
         x = x ^ (x >> 33);
         x = x * rhh_pkg::MIX64_C1;
         x = x ^ (x >> 33);
         x = x * rhh_pkg::MIX64_C2;
         x = x ^ (x >> 33);
         h = x[31:0];
      end else begin
         x = key & mode_mask();
         h = x[31:0];
         h = h ^ (h >> 16);
         h = h * rhh_pkg::MIX32_C1[31:0];
         h = h ^ (h >> 13);
         h = h * rhh_pkg::MIX32_C2[31:0];
         h = h ^ (h >> 16);
      end
      h = h & ~rhh_pkg::HASH_DEL;
      if (h == 0) h = 1;
      return h;
   endfunction

   function automatic int unsigned dist_from_home(input int unsigned idx,
                                                  input logic [rhh_pkg::HASH_W-1:0] h);
      return (idx - h) & (rhh_pkg::SLOTS - 1);
   endfunction

   function automatic answer_type table_answer(input logic [rhh_pkg::ST_W-1:0] st,
                                               input logic [rhh_pkg::VAL_W-1:0] v,
                                               input int unsigned nd);
      answer_type a;
      a.status = st;
      a.found_value = v;
      a.next_distance = nd[rhh_pkg::DIST_W-1:0];
      a.entry_total = live_total[rhh_pkg::CNT_W-1:0];
      return a;
   endfunction

   function automatic answer_type table_lookup(input logic [rhh_pkg::KEY_W-1:0] key,
                                               input int unsigned start);
      logic [rhh_pkg::HASH_W-1:0] h, bh;
      logic [rhh_pkg::KEY_W-1:0] m;
      int unsigned idx;
      h = murmur_hash(key);
      m = mode_mask();
      for (int unsigned d = start; d < rhh_pkg::SLOTS; d++) begin
         idx = (h + d) & (rhh_pkg::SLOTS - 1);
         bh = tbl_hash[idx];
         if (bh == h) begin
            if ((tbl_key[idx] & m) == (key & m))
               return table_answer(rhh_pkg::ST_OK, tbl_val[idx], d + 1);
         end else if (bh == 0 || dist_from_home(idx, bh) < d) begin
            break;
         end
      end
      return table_answer(rhh_pkg::ST_NOTFOUND, 0, 0);
   endfunction

   function automatic answer_type table_insert(input logic [rhh_pkg::KEY_W-1:0] key,
                                               input logic [rhh_pkg::VAL_W-1:0] val);
      logic [rhh_pkg::HASH_W-1:0] h, bh, th;
      logic [rhh_pkg::KEY_W-1:0] k, tk;
      logic [rhh_pkg::VAL_W-1:0] v, tv;
      int unsigned idx, bd, steps, d;
      bit steal;
      if (live_total >= limit_entries || live_total >= rhh_pkg::SLOTS)
         return table_answer(rhh_pkg::ST_FULL, 0, 0);
      h = murmur_hash(key);
      k = key & mode_mask();
      v = val;
      steps = 0;
      for (d = 0; d < rhh_pkg::SLOTS && steps < rhh_pkg::SLOTS * rhh_pkg::SLOTS;
           d++, steps++) begin
         idx = (h + d) & (rhh_pkg::SLOTS - 1);
         bh = tbl_hash[idx];
         bd = dist_from_home(idx, bh);
         steal = d > bd;
         if (bh == 0 || (bh[31] && steal)) begin
            tbl_hash[idx] = h;
            tbl_key[idx] = k;
            tbl_val[idx] = v;
            live_total++;
            return table_answer(rhh_pkg::ST_OK, 0, 0);
         end else if (steal) begin
            tk = tbl_key[idx];
            tv = tbl_val[idx];
            th = bh;
            tbl_hash[idx] = h;
            tbl_key[idx] = k;
            tbl_val[idx] = v;
            h = th;
            k = tk;
            v = tv;
            d = bd;
         end
      end
      return table_answer(rhh_pkg::ST_FULL, 0, 0);
   endfunction

   function automatic answer_type table_remove(input logic [rhh_pkg::KEY_W-1:0] key,
                                               input logic [rhh_pkg::VAL_W-1:0] val);
      logic [rhh_pkg::HASH_W-1:0] h;
      int unsigned idx;
      h = murmur_hash(key);
      for (int unsigned d = 0; d < rhh_pkg::SLOTS; d++) begin
         idx = (h + d) & (rhh_pkg::SLOTS - 1);
         if (tbl_hash[idx] == h && tbl_val[idx] == val) begin
            tbl_hash[idx] = h | rhh_pkg::HASH_DEL;
            if (live_total > 0) live_total--;
            return table_answer(rhh_pkg::ST_OK, 0, 0);
         end
      end
      return table_answer(rhh_pkg::ST_NOTFOUND, 0, 0);
   endfunction

   function automatic answer_type table_step(input logic [rhh_pkg::OP_W-1:0] op,
                                             input logic [rhh_pkg::KEY_W-1:0] key,
                                             input logic [rhh_pkg::VAL_W-1:0] val,
                                             input logic [rhh_pkg::DIST_W-1:0] rd);
      case (op)
         rhh_pkg::OP_LOOKUP: return table_lookup(key, rd);
         rhh_pkg::OP_INSERT: return table_insert(key, val);
         rhh_pkg::OP_REMOVE: return table_remove(key, val);
         default:            return table_answer(rhh_pkg::ST_NOTFOUND, 0, 0);
      endcase
   endfunction

   // one request transfer; the answer is predicted at acceptance
   task automatic send_request(input logic [rhh_pkg::OP_W-1:0] op,
                               input logic [rhh_pkg::KEY_W-1:0] key,
                               input logic [rhh_pkg::VAL_W-1:0] val,
                               input logic [rhh_pkg::DIST_W-1:0] rd);
      while (!busy_free && $urandom_range(0, 99) < 17) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.op = op;
      req_bus.key = key;
      req_bus.value = val;
      req_bus.resume_distance = rd;
      do @(posedge clock); while (!req_bus.ready);
      pending_answers.push_back(table_step(op, key, val, rd));
      if (op == rhh_pkg::OP_INSERT && pending_answers[$].status == rhh_pkg::ST_OK)
         stored_pairs.push_back({key, val});
      @(negedge clock);
   endtask

   task automatic drain_answers();
      req_bus.valid = 1'b0;
      while (pending_answers.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_csr(input logic [rhh_pkg::CSR_IDX_W-1:0] idx,
                            input int unsigned data);
      drain_answers();
      csr_we = 1'b1;
      csr_index = idx;
      csr_data = data[rhh_pkg::CSR_W-1:0];
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == rhh_pkg::REG_MAX_ENTRIES) limit_entries = data & 10'h3ff;
      else cur_mode = data[rhh_pkg::MODE_W-1:0];
   endtask

   // walks up to six duplicates of a key through next_distance
   task automatic walk_duplicates(input logic [rhh_pkg::KEY_W-1:0] key);
      answer_type a;
      int unsigned rd;
      rd = 0;
      repeat (6) begin
         a = table_lookup(key, rd);
         send_request(rhh_pkg::OP_LOOKUP, key, 0, rd[rhh_pkg::DIST_W-1:0]);
         if (a.status != rhh_pkg::ST_OK) break;
         rd = a.next_distance;
      end
   endtask

   task automatic test_field_extremes();
      send_request(rhh_pkg::OP_LOOKUP, 64'h0, 32'h0, 11'd0);
      send_request(rhh_pkg::OP_INSERT, 64'h0, 32'h0, 11'd0);
      send_request(rhh_pkg::OP_INSERT, '1, '1, '1);
      send_request(rhh_pkg::OP_LOOKUP, '1, 32'h0, 11'd0);
      send_request(rhh_pkg::OP_LOOKUP, 64'h0, 32'h0, 11'd1023);
      send_request(rhh_pkg::OP_LOOKUP, 64'h0, 32'h0, 11'd1024);
      send_request(rhh_pkg::OP_LOOKUP, 64'h0, 32'h0, 11'h7ff);
      send_request(rhh_pkg::OP_UNDEF, '1, '1, '1);
      send_request(rhh_pkg::OP_REMOVE, 64'h0, 32'h1, 11'd0);
      send_request(rhh_pkg::OP_REMOVE, 64'h0, 32'h0, 11'd0);
      send_request(rhh_pkg::OP_LOOKUP, 64'h0, 32'h0, 11'd0);
   endtask

   task automatic test_duplicates();
      for (int i = 0; i < 4; i++)
         send_request(rhh_pkg::OP_INSERT, 64'h1234, 32'h100 + i, 11'd0);
      walk_duplicates(64'h1234);
      send_request(rhh_pkg::OP_REMOVE, 64'h1234, 32'h101, 11'd0);
      walk_duplicates(64'h1234);
      send_request(rhh_pkg::OP_INSERT, 64'hdead_0000_0000_1234, 32'h200, 11'd0);
      walk_duplicates(64'h1234);
   endtask

   task automatic test_refused_when_full();
      write_csr(rhh_pkg::REG_MAX_ENTRIES, live_total + 1);
      send_request(rhh_pkg::OP_INSERT, 64'h77, 32'h77, 11'd0);
      send_request(rhh_pkg::OP_INSERT, 64'h78, 32'h78, 11'd0);
      write_csr(rhh_pkg::REG_MAX_ENTRIES, 1);
      send_request(rhh_pkg::OP_INSERT, 64'h79, 32'h79, 11'd0);
   endtask

   task automatic test_mode_change();
      write_csr(rhh_pkg::REG_MAX_ENTRIES, 1023);
      write_csr(rhh_pkg::REG_KEY_MODE, rhh_pkg::KEY_MODE_16);
      send_request(rhh_pkg::OP_LOOKUP, 64'h1234, 32'h0, 11'd0);
      send_request(rhh_pkg::OP_LOOKUP, 64'hffff_ffff_ffff_1234, 32'h0, 11'd0);
      write_csr(rhh_pkg::REG_KEY_MODE, rhh_pkg::KEY_MODE_UNDEF);
      send_request(rhh_pkg::OP_INSERT, 64'hfedc_ba98_7654_3210, 32'h5, 11'd0);
      send_request(rhh_pkg::OP_LOOKUP, 64'hfedc_ba98_7654_3210, 32'h0, 11'd0);
   endtask

   // mostly coherent traffic on a key pool of the given size, some noise
   task automatic run_random(input int n, input int pool);
      logic [rhh_pkg::KEY_W-1:0] key;
      logic [rhh_pkg::VAL_W-1:0] val;
      pair_type p;
      int pick, j;
      for (int i = 0; i < n; i++) begin
         key = {$urandom, $urandom};
         key = (key & ~mode_mask()) | $urandom_range(0, pool);
         val = $urandom_range(0, 7);
         pick = $urandom_range(0, 99);
         if (i == n / 2) drain_answers();
         if (pick < 40) begin
            send_request(rhh_pkg::OP_INSERT, key, val, 11'($urandom));
         end else if (pick < 60 && stored_pairs.size() != 0) begin
            j = $urandom_range(0, stored_pairs.size() - 1);
            p = stored_pairs[j];
            stored_pairs.delete(j);
            send_request(rhh_pkg::OP_REMOVE, p.key,
                         p.value ^ ($urandom_range(0, 9) == 0), 11'd0);
         end else if (pick < 75) begin
            send_request(rhh_pkg::OP_LOOKUP, key, $urandom, 11'd0);
         end else if (pick < 85) begin
            walk_duplicates(key);
         end else if (pick < 92) begin
            send_request(rhh_pkg::OP_LOOKUP, key, $urandom, 11'($urandom_range(0, 12)));
         end else begin
            send_request(2'($urandom), {$urandom, $urandom}, $urandom, 11'($urandom));
         end
      end
   endtask

   // response checking
   always @(posedge clock) begin
      answer_type want;
      if (rsp_bus.valid && rsp_bus.ready) begin
         if (pending_answers.size() == 0) begin
            $error("response with none expected");
            failures++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_bus.status !== want.status) begin
               $error("status expected %0d got %0d", want.status, rsp_bus.status);
               failures++;
            end
            if (rsp_bus.found_value !== want.found_value) begin
               $error("found_value expected %h got %h", want.found_value,
                      rsp_bus.found_value);
               failures++;
            end
            if (rsp_bus.next_distance !== want.next_distance) begin
               $error("next_distance expected %0d got %0d", want.next_distance,
                      rsp_bus.next_distance);
               failures++;
            end
            if (rsp_bus.entry_total !== want.entry_total) begin
               $error("entry_total expected %0d got %0d", want.entry_total,
                      rsp_bus.entry_total);
               failures++;
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_bus.ready <= busy_free || ($urandom_range(0, 99) >= 17);
   end

   // cycles without any transfer
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 60000) begin
         $display("FAIL robin_hood_hash_table_unit");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < rhh_pkg::SLOTS; i++) begin
         tbl_hash[i] = '0;
         tbl_key[i] = '0;
         tbl_val[i] = '0;
      end
      live_total = 0;
      limit_entries = rhh_pkg::MAX_ENTRIES_RST;
      cur_mode = rhh_pkg::KEY_MODE_RST;
      repeat (12) @(negedge clock);
      reset = 1'b0;
      test_field_extremes();
      test_duplicates();
      test_refused_when_full();
      test_mode_change();
      busy_free = 1;
      run_random(120, 300);
      busy_free = 0;
      write_csr(rhh_pkg::REG_KEY_MODE, rhh_pkg::KEY_MODE_32);
      run_random(100, 200);
      write_csr(rhh_pkg::REG_KEY_MODE, rhh_pkg::KEY_MODE_16);
      write_csr(rhh_pkg::REG_MAX_ENTRIES, 30);
      run_random(80, 60);
      write_csr(rhh_pkg::REG_KEY_MODE, rhh_pkg::KEY_MODE_64);
      write_csr(rhh_pkg::REG_MAX_ENTRIES, 1023);
      run_random(100, 100000);
      drain_answers();
      if (failures == 0)
         $display("PASS robin_hood_hash_table_unit");
      else
         $display("FAIL robin_hood_hash_table_unit");
      $finish;
   end

endmodule
